// ===== hdl/lzd_pkg.sv =====
// Shared constants and types for the LZ tag stream decompressor.
package lzd_pkg;

    localparam int WIN_AW   = 12;
    localparam int LEN_W    = 24;
    localparam int PLEN_W   = 9;
    localparam int DATA_W   = 64;
    localparam int CNT_W    = 4;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_RAW_SIZE  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LEN_CHECK = 1'd1;

    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_CORRUPT    = 2'd1;
    localparam logic [1:0] ST_INCOMPLETE = 2'd2;

    localparam logic [PLEN_W-1:0] LEN_BASE = 9'd3;
    localparam logic [PLEN_W-1:0] LEN_EXT  = 9'd18;
    localparam logic [3:0]        GROUP_ITEMS = 4'd8;

    typedef enum logic [1:0] {
        PH_START = 2'd0,
        PH_TAG1  = 2'd1,
        PH_EXT   = 2'd2
    } t_phase;

    typedef struct packed {
        logic              we;
        logic [WIN_AW-1:0] waddr;
        logic [7:0]        wdata;
        logic              re;
        logic [WIN_AW-1:0] raddr;
    } t_ram_req;

endpackage

// ===== hdl/lzd_in_if.sv =====
// Compressed input word channel.
interface lzd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       in_last;
    modport source (output valid, in_byte, in_last, input ready);
    modport sink   (input valid, in_byte, in_last, output ready);
endinterface

// ===== hdl/lzd_out_if.sv =====
// Decompressed output word channel.
interface lzd_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] out_data;
    logic [3:0]  out_count;
    logic        out_run_last;
    logic        out_final;
    logic [1:0]  out_status;
    logic [23:0] out_total;
    modport source (output valid, out_data, out_count, out_run_last, out_final,
                    out_status, out_total, input ready);
    modport sink   (input valid, out_data, out_count, out_run_last, out_final,
                    out_status, out_total, output ready);
endinterface

// ===== hdl/lzd_hist_ram.sv =====
// History window memory: one write and one registered read port.
module lzd_hist_ram (
    input  logic              i_clk,
    input  lzd_pkg::t_ram_req i_req,
    output logic [7:0]        o_rdata
);
    import lzd_pkg::*;

    logic [7:0] r_mem [0:(1<<WIN_AW)-1];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_rdata <= r_mem[i_req.raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ===== hdl/lz_tag_stream_decompressor_top.sv =====
// Top level of the LZ tag stream decompressor.
//
// Takes one compressed byte per input word and emits decoded bytes in beats of
// up to BEAT_BYTES bytes, plus one status word after the byte marked last.
// A control byte, a tag byte without copy or a literal is handled in S_IDLE.
// A completed tag of L copied bytes is copied byte by byte after the byte
// that completes it: each byte is read from the 4096-byte history RAM in S_RD
// and written back from S_WR, so the single RAM port pair copies one byte at
// a time. The status word is sent from S_FIN. A full output register that is
// not drained holds the engine. Input is taken only while no tag copy or
// status word is in flight. Configuration (raw_size at index 0, the length
// check flag at index 1) is to be written by the user only between streams
// or while idle; the block itself does not enforce this.
module lz_tag_stream_decompressor_top #(
    parameter int BEAT_BYTES = 8
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [lzd_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [lzd_pkg::LEN_W-1:0]      i_cfg_data,
    lzd_in_if.sink                         i_in,
    lzd_out_if.source                      o_out
);
    import lzd_pkg::*;

    localparam logic [CNT_W-1:0] BEAT_N = CNT_W'(BEAT_BYTES);

    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_RD   = 2'd1,
        S_WR   = 2'd2,
        S_FIN  = 2'd3
    } t_state;

    // control state
    t_state              r_state;
    t_phase              r_phase;
    logic [7:0]          r_ctrl;
    logic [3:0]          r_left;
    logic [PLEN_W-1:0]   r_plen;
    logic [WIN_AW-1:0]   r_poff;
    logic [LEN_W-1:0]    r_prod;
    logic                r_err;
    logic                r_lefto;
    logic                r_fin_pend;
    logic [LEN_W-1:0]    r_raw;
    logic                r_chk;
    // copy engine
    logic [WIN_AW-1:0]   r_src;
    logic [PLEN_W-1:0]   r_len;
    logic [DATA_W-1:0]   r_acc;
    logic [CNT_W-1:0]    r_bcnt;
    // output register
    logic                r_ov;
    logic [DATA_W-1:0]   r_odata;
    logic [CNT_W-1:0]    r_ocnt;
    logic                r_orl;
    logic                r_ofin;
    logic [1:0]          r_ost;
    logic [LEN_W-1:0]    r_otot;

    t_ram_req            w_req;
    logic [7:0]          w_q;
    logic                w_out_free;
    logic                w_acc_in;
    logic [LEN_W-1:0]    w_missing;
    logic [WIN_AW-1:0]   w_off;
    logic [PLEN_W-1:0]   w_len_full;
    logic [PLEN_W-1:0]   w_len;
    logic                w_bad;
    logic                w_beat_done;
    logic [DATA_W-1:0]   w_acc_nx;
    logic                w_adv;
    logic [1:0]          w_status;

    lzd_hist_ram u_ram (
        .i_clk   (i_clk),
        .i_req   (w_req),
        .o_rdata (w_q)
    );

    assign w_out_free = !r_ov || o_out.ready;
    assign i_in.ready = (r_state == S_IDLE) && w_out_free;
    assign w_acc_in   = i_in.valid && i_in.ready;

    // tag decode for the byte that completes a tag
    always_comb begin
        w_missing  = (r_raw > r_prod) ? r_raw - r_prod : '0;
        w_off      = (r_phase == PH_TAG1) ? {r_poff[11:8], i_in.in_byte} : r_poff;
        w_len_full = (r_phase == PH_EXT) ? r_plen + {1'b0, i_in.in_byte} : r_plen;
        w_bad      = (w_off == '0) || ({{(LEN_W-WIN_AW){1'b0}}, w_off} > r_prod);
        w_len      = ({{(LEN_W-PLEN_W){1'b0}}, w_len_full} > w_missing)
                     ? w_missing[PLEN_W-1:0] : w_len_full;
    end

    // copy step: merge the fetched byte into the beat
    always_comb begin
        w_acc_nx = r_acc;
        w_acc_nx[8*r_bcnt[2:0] +: 8] = w_q;
        w_beat_done = (r_bcnt + 1'b1 == BEAT_N) || (r_len == 9'd1);
        w_adv = (r_state == S_WR) && (!w_beat_done || w_out_free);
    end

    always_comb begin
        w_status = ST_OK;
        if (r_err) begin
            w_status = ST_CORRUPT;
        end else if (r_chk && ((r_prod != r_raw) || r_lefto)) begin
            w_status = ST_INCOMPLETE;
        end
    end

    // literals and copied bytes share the write port; reads only from S_RD
    always_comb begin
        w_req.waddr = r_prod[WIN_AW-1:0];
        w_req.raddr = r_src;
        w_req.re    = (r_state == S_RD);
        w_req.we    = 1'b0;
        w_req.wdata = i_in.in_byte;
        if (w_adv) begin
            w_req.we    = 1'b1;
            w_req.wdata = w_q;
        end else if (w_acc_in && !r_err && r_phase == PH_START && r_prod < r_raw
                     && r_left != '0 && !r_ctrl[0]) begin
            w_req.we = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_phase    <= PH_START;
            r_ctrl     <= '0;
            r_left     <= '0;
            r_plen     <= '0;
            r_poff     <= '0;
            r_prod     <= '0;
            r_err      <= 1'b0;
            r_lefto    <= 1'b0;
            r_fin_pend <= 1'b0;
            r_raw      <= '0;
            r_chk      <= 1'b1;
            r_ov       <= 1'b0;
            r_len      <= '0;
            r_bcnt     <= '0;
        end else begin
            if (o_out.ready) begin
                r_ov <= 1'b0;
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_RAW_SIZE:  r_raw <= i_cfg_data;
                    CFG_LEN_CHECK: r_chk <= i_cfg_data[0];
                    default: ;
                endcase
            end
            case (r_state)
                S_IDLE: begin
                    if (w_acc_in) begin
                        r_fin_pend <= i_in.in_last;
                        if (i_in.in_last) begin
                            r_state <= S_FIN;
                        end
                        if (!r_err) begin
                            case (r_phase)
                                PH_START: begin
                                    if (r_prod >= r_raw) begin
                                        r_lefto <= 1'b1;
                                    end else if (r_left == '0) begin
                                        r_ctrl <= i_in.in_byte;
                                        r_left <= GROUP_ITEMS;
                                    end else if (r_ctrl[0]) begin
                                        r_plen  <= {5'd0, i_in.in_byte[3:0]} + LEN_BASE;
                                        r_poff  <= {i_in.in_byte[7:4], 8'd0};
                                        r_phase <= PH_TAG1;
                                        // tag cut off by the last byte
                                        if (i_in.in_last) begin
                                            r_err <= 1'b1;
                                        end
                                    end else begin
                                        r_prod  <= r_prod + 1'b1;
                                        r_ctrl  <= {1'b0, r_ctrl[7:1]};
                                        r_left  <= r_left - 1'b1;
                                        r_ov    <= 1'b1;
                                        r_odata <= {{(DATA_W-8){1'b0}}, i_in.in_byte};
                                        r_ocnt  <= CNT_W'(1);
                                        r_orl   <= !i_in.in_last;
                                        r_ofin  <= 1'b0;
                                        r_ost   <= ST_OK;
                                        r_otot  <= '0;
                                    end
                                end
                                default: begin
                                    if (r_phase == PH_TAG1 && r_plen == LEN_EXT) begin
                                        r_poff  <= w_off;
                                        r_phase <= PH_EXT;
                                        if (i_in.in_last) begin
                                            r_err <= 1'b1;
                                        end
                                    end else begin
                                        r_phase <= PH_START;
                                        if (w_bad) begin
                                            r_err <= 1'b1;
                                        end else begin
                                            r_ctrl <= {1'b0, r_ctrl[7:1]};
                                            if (r_left != '0) begin
                                                r_left <= r_left - 1'b1;
                                            end
                                            if (w_len != '0) begin
                                                r_len   <= w_len;
                                                r_src   <= r_prod[WIN_AW-1:0] - w_off;
                                                r_bcnt  <= '0;
                                                r_acc   <= '0;
                                                r_state <= S_RD;
                                            end
                                        end
                                    end
                                end
                            endcase
                        end
                    end
                end
                S_RD: begin
                    r_state <= S_WR;
                end
                S_WR: begin
                    // hold the fetched byte until the output register frees up
                    if (w_adv) begin
                        r_prod <= r_prod + 1'b1;
                        r_src  <= r_src + 1'b1;
                        r_len  <= r_len - 1'b1;
                        if (w_beat_done) begin
                            r_ov    <= 1'b1;
                            r_odata <= w_acc_nx;
                            r_ocnt  <= r_bcnt + 1'b1;
                            r_orl   <= (r_len == 9'd1) && !r_fin_pend;
                            r_ofin  <= 1'b0;
                            r_ost   <= ST_OK;
                            r_otot  <= '0;
                            r_acc   <= '0;
                            r_bcnt  <= '0;
                        end else begin
                            r_acc  <= w_acc_nx;
                            r_bcnt <= r_bcnt + 1'b1;
                        end
                        if (r_len == 9'd1) begin
                            r_state <= r_fin_pend ? S_FIN : S_IDLE;
                        end else begin
                            r_state <= S_RD;
                        end
                    end
                end
                S_FIN: begin
                    if (w_out_free) begin
                        r_ov       <= 1'b1;
                        r_odata    <= '0;
                        r_ocnt     <= '0;
                        r_orl      <= 1'b1;
                        r_ofin     <= 1'b1;
                        r_ost      <= w_status;
                        r_otot     <= r_prod;
                        // drop all stream state for the next stream
                        r_phase    <= PH_START;
                        r_ctrl     <= '0;
                        r_left     <= '0;
                        r_plen     <= '0;
                        r_poff     <= '0;
                        r_prod     <= '0;
                        r_err      <= 1'b0;
                        r_lefto    <= 1'b0;
                        r_fin_pend <= 1'b0;
                        r_state    <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out.valid        = r_ov;
    assign o_out.out_data     = r_odata;
    assign o_out.out_count    = r_ocnt;
    assign o_out.out_run_last = r_orl;
    assign o_out.out_final    = r_ofin;
    assign o_out.out_status   = r_ost;
    assign o_out.out_total    = r_otot;
endmodule

// ===== hdl/lzd_checker.sv =====
// Port-level checks for the LZ tag stream decompressor and their binding.
module lzd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [63:0] i_out_data,
    input logic [3:0]  i_out_count,
    input logic        i_out_run_last,
    input logic        i_out_final,
    input logic [1:0]  i_out_status
);
    a_final_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_final |-> i_out_count == 4'd0 && i_out_data == 64'd0
                                       && i_out_run_last)
        else $error("status word carries data or lacks run_last");

    a_beat_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_final |-> i_out_count != 4'd0 && i_out_count <= 4'd8
                                        && i_out_status == 2'd0)
        else $error("data beat with bad count or status");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_out_status != 2'd3)
        else $error("undefined status code");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_data)
                                        && $stable(i_out_count))
        else $error("stalled output word changed");
endmodule

bind lz_tag_stream_decompressor_top lzd_checker u_lzd_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_out_data     (o_out.out_data),
    .i_out_count    (o_out.out_count),
    .i_out_run_last (o_out.out_run_last),
    .i_out_final    (o_out.out_final),
    .i_out_status   (o_out.out_status)
);
